// File: hdl/lcd4_pkg.sv
// Shared types and the microprogram for the 4-bit character LCD sequencer.
// Used by lcd4_ctrl and lcd_4bit_nibble_sequencer; depends on nothing.
package lcd4_pkg;

  typedef enum logic [2:0] {
    OP_INIT        = 3'd0,
    OP_CMD         = 3'd1,
    OP_CHAR        = 3'd2,
    OP_CURSOR      = 3'd3,
    OP_CURSOR_CHAR = 3'd4
  } op_e;

  // where the nibble of a write comes from
  typedef enum logic [2:0] {
    NS_CONST  = 3'd0,
    NS_VAL_HI = 3'd1,
    NS_VAL_LO = 3'd2,
    NS_ADR_HI = 3'd3,
    NS_ADR_LO = 3'd4
  } nsrc_e;

  // sequencing after a step
  typedef enum logic [1:0] {
    SQ_NEXT   = 2'd0,
    SQ_END    = 2'd1,
    SQ_BRANCH = 2'd2   // jump to the character routine if one follows, else end
  } seq_e;

  typedef struct packed {
    nsrc_e       nsrc;
    logic [3:0]  cnib;
    logic        rs;
    logic        en;
    logic [8:0]  wait_units;
    seq_e        seq;
  } uword_t;

  typedef struct packed {
    logic active;  // a write is issued at the coming edge
    logic last;    // that write ends the run
  } seq_status_t;

  localparam int unsigned PcW = 6;

  localparam logic [PcW-1:0] EntryInit   = 6'd0;
  localparam logic [PcW-1:0] EntryCmd    = 6'd25;
  localparam logic [PcW-1:0] EntryCursor = 6'd29;
  localparam logic [PcW-1:0] EntryChar   = 6'd33;

  localparam logic [8:0] CmdWait = 9'd50;
  localparam logic [8:0] ChrWait = 9'd1;

  function automatic uword_t mk(nsrc_e nsrc, logic [3:0] cnib, logic rs, logic en,
                                logic [8:0] wt, seq_e seq);
    uword_t w;
    w.nsrc       = nsrc;
    w.cnib       = cnib;
    w.rs         = rs;
    w.en         = en;
    w.wait_units = wt;
    w.seq        = seq;
    return w;
  endfunction

  // Microprogram: wake-up, init commands, command, cursor, character routines.
  function automatic uword_t rom_word(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      // wake-up
      6'd0:  w = mk(NS_CONST,  4'h0, 1'b0, 1'b0, 9'd500, SQ_NEXT);
      6'd1:  w = mk(NS_CONST,  4'h3, 1'b0, 1'b1, 9'd125, SQ_NEXT);
      6'd2:  w = mk(NS_CONST,  4'h3, 1'b0, 1'b0, 9'd0,   SQ_NEXT);
      6'd3:  w = mk(NS_CONST,  4'h3, 1'b0, 1'b1, 9'd3,   SQ_NEXT);
      6'd4:  w = mk(NS_CONST,  4'h3, 1'b0, 1'b0, 9'd0,   SQ_NEXT);
      6'd5:  w = mk(NS_CONST,  4'h3, 1'b0, 1'b1, 9'd125, SQ_NEXT);
      6'd6:  w = mk(NS_CONST,  4'h3, 1'b0, 1'b0, 9'd0,   SQ_NEXT);
      6'd7:  w = mk(NS_CONST,  4'h2, 1'b0, 1'b1, 9'd125, SQ_NEXT);
      6'd8:  w = mk(NS_CONST,  4'h2, 1'b0, 1'b0, 9'd0,   SQ_NEXT);
      // function set, 4-bit, two lines
      6'd9:  w = mk(NS_CONST,  4'h2, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd10: w = mk(NS_CONST,  4'h2, 1'b0, 1'b0, 9'd0,    SQ_NEXT);
      6'd11: w = mk(NS_CONST,  4'h8, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd12: w = mk(NS_CONST,  4'h8, 1'b0, 1'b0, 9'd0,    SQ_NEXT);
      // display on
      6'd13: w = mk(NS_CONST,  4'h0, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd14: w = mk(NS_CONST,  4'h0, 1'b0, 1'b0, 9'd0,    SQ_NEXT);
      6'd15: w = mk(NS_CONST,  4'hC, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd16: w = mk(NS_CONST,  4'hC, 1'b0, 1'b0, 9'd0,    SQ_NEXT);
      // clear
      6'd17: w = mk(NS_CONST,  4'h0, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd18: w = mk(NS_CONST,  4'h0, 1'b0, 1'b0, 9'd0,    SQ_NEXT);
      6'd19: w = mk(NS_CONST,  4'h1, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd20: w = mk(NS_CONST,  4'h1, 1'b0, 1'b0, 9'd0,    SQ_NEXT);
      // entry mode
      6'd21: w = mk(NS_CONST,  4'h0, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd22: w = mk(NS_CONST,  4'h0, 1'b0, 1'b0, 9'd0,    SQ_NEXT);
      6'd23: w = mk(NS_CONST,  4'h6, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd24: w = mk(NS_CONST,  4'h6, 1'b0, 1'b0, 9'd0,    SQ_END);
      // command byte
      6'd25: w = mk(NS_VAL_HI, 4'h0, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd26: w = mk(NS_VAL_HI, 4'h0, 1'b0, 1'b0, 9'd0,    SQ_NEXT);
      6'd27: w = mk(NS_VAL_LO, 4'h0, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd28: w = mk(NS_VAL_LO, 4'h0, 1'b0, 1'b0, 9'd0,    SQ_END);
      // cursor address
      6'd29: w = mk(NS_ADR_HI, 4'h0, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd30: w = mk(NS_ADR_HI, 4'h0, 1'b0, 1'b0, 9'd0,    SQ_NEXT);
      6'd31: w = mk(NS_ADR_LO, 4'h0, 1'b0, 1'b1, CmdWait, SQ_NEXT);
      6'd32: w = mk(NS_ADR_LO, 4'h0, 1'b0, 1'b0, 9'd0,    SQ_BRANCH);
      // character byte
      6'd33: w = mk(NS_VAL_HI, 4'h0, 1'b1, 1'b1, ChrWait, SQ_NEXT);
      6'd34: w = mk(NS_VAL_HI, 4'h0, 1'b1, 1'b0, 9'd0,    SQ_NEXT);
      6'd35: w = mk(NS_VAL_LO, 4'h0, 1'b1, 1'b1, ChrWait, SQ_NEXT);
      6'd36: w = mk(NS_VAL_LO, 4'h0, 1'b1, 1'b0, 9'd0,    SQ_END);
      default: w = mk(NS_CONST, 4'h0, 1'b0, 1'b0, 9'd0,   SQ_END);
    endcase
    return w;
  endfunction

endpackage

// File: hdl/lcd4_ctrl.sv
// Microsequencer: step counter, program fetch and the busy/branch control.
// Depends on lcd4_pkg for the control word layout and the microprogram.
module lcd4_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2:0]           op_i,
  output logic                 busy_o,
  output lcd4_pkg::uword_t     uword_o,
  output lcd4_pkg::seq_status_t status_o
);

  logic [lcd4_pkg::PcW-1:0] pc_q, pc_d;
  logic                     run_q, run_d;
  logic                     op4_q, op4_d;
  logic [lcd4_pkg::PcW-1:0] entry;
  logic                     op_known;
  logic                     fin;
  logic                     accept;
  lcd4_pkg::uword_t         word;

  assign word = lcd4_pkg::rom_word(pc_q);

  // the step being issued ends the run
  assign fin = run_q && ((word.seq == lcd4_pkg::SQ_END) ||
                         ((word.seq == lcd4_pkg::SQ_BRANCH) && !op4_q));

  // take the next transaction while the final write goes out
  assign busy_o = run_q && !fin;
  assign accept = start_i && !busy_o;

  always_comb begin
    entry    = lcd4_pkg::EntryInit;
    op_known = 1'b1;
    unique case (lcd4_pkg::op_e'(op_i))
      lcd4_pkg::OP_INIT:        entry = lcd4_pkg::EntryInit;
      lcd4_pkg::OP_CMD:         entry = lcd4_pkg::EntryCmd;
      lcd4_pkg::OP_CHAR:        entry = lcd4_pkg::EntryChar;
      lcd4_pkg::OP_CURSOR:      entry = lcd4_pkg::EntryCursor;
      lcd4_pkg::OP_CURSOR_CHAR: entry = lcd4_pkg::EntryCursor;
      default:                  op_known = 1'b0;
    endcase
  end

  always_comb begin
    pc_d  = pc_q;
    run_d = run_q;
    op4_d = op4_q;
    priority if (accept) begin
      pc_d  = entry;
      run_d = op_known;
      op4_d = (lcd4_pkg::op_e'(op_i) == lcd4_pkg::OP_CURSOR_CHAR);
    end else if (fin) begin
      run_d = 1'b0;
    end else if (run_q) begin
      if (word.seq == lcd4_pkg::SQ_BRANCH) begin
        pc_d = lcd4_pkg::EntryChar;
      end else begin
        pc_d = pc_q + 6'd1;
      end
    end else begin
      // idle: hold
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= lcd4_pkg::EntryInit;
      run_q <= 1'b0;
      op4_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      run_q <= run_d;
      op4_q <= op4_d;
    end
  end

  assign uword_o         = word;
  assign status_o.active = run_q;
  assign status_o.last   = fin;

endmodule

// File: hdl/lcd_4bit_nibble_sequencer.sv
// Top level of the 4-bit character LCD sequencer: operand registers, cursor
// address adder and registered write outputs. Depends on lcd4_pkg, lcd4_ctrl.
//
// A request is taken when start is high and busy is low. It becomes a run
// of port writes, one per clock cycle, each shown for one cycle with strobe_o
// high; the receiver cannot stall them, so it must take every strobed write.
// The request is registered in the step counter, and each fetched step in the
// write outputs, before its write appears. Command, data and set cursor give
// 4 writes, set cursor then char gives 8, init gives 25; op codes 5 to 7 are
// taken and give nothing. busy drops in the cycle that fetches the last step
// of a run, the cycle before the last write shows, so a new request follows
// without a gap and a stream of byte requests runs back to back. One
// microprogram step is fetched per cycle; that step counter sets the rate.
module lcd_4bit_nibble_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op_i,
  input  logic [7:0] value_i,
  input  logic [1:0] row_i,
  input  logic [5:0] column_i,
  output logic       strobe_o,
  output logic [3:0] data_nibble_o,
  output logic       reg_select_o,
  output logic       enable_o,
  output logic [8:0] wait_units_o,
  output logic       last_o
);

  lcd4_pkg::uword_t      uword;
  lcd4_pkg::seq_status_t status;
  logic                  accept;
  logic [7:0]            value_q;
  logic [7:0]            addr_q;
  logic [7:0]            addr_d;
  logic [3:0]            nib;
  logic                  strobe_q;
  logic [3:0]            nib_q;
  logic                  rs_q;
  logic                  en_q;
  logic [8:0]            wait_q;
  logic                  last_q;

  lcd4_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (op_i),
    .busy_o   (busy),
    .uword_o  (uword),
    .status_o (status)
  );

  assign accept = start && !busy;

  // DDRAM address: 0x80 + (row-1)*0x40 + (column-1), wrapping at 8 bits
  assign addr_d = 8'h80 + {row_i - 2'd1, 6'd0} + ({2'b00, column_i} - 8'd1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    unique case (uword.nsrc)
      lcd4_pkg::NS_CONST:  nib = uword.cnib;
      lcd4_pkg::NS_VAL_HI: nib = value_q[7:4];
      lcd4_pkg::NS_VAL_LO: nib = value_q[3:0];
      lcd4_pkg::NS_ADR_HI: nib = addr_q[7:4];
      lcd4_pkg::NS_ADR_LO: nib = addr_q[3:0];
      default:             nib = uword.cnib;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= status.active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.active) begin
      nib_q  <= nib;
      rs_q   <= uword.rs;
      en_q   <= uword.en;
      wait_q <= uword.wait_units;
      last_q <= status.last;
    end
  end

  assign strobe_o      = strobe_q;
  assign data_nibble_o = nib_q;
  assign reg_select_o  = rs_q;
  assign enable_o      = en_q;
  assign wait_units_o  = wait_q;
  assign last_o        = strobe_q && last_q;

  // a known op puts out its first write through the step counter, then the write registers
  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i <= lcd4_pkg::OP_CURSOR_CHAR) |=> ##1 strobe_o)
    else $error("accepted request gave no write");

  // while busy, a write is always issued next cycle
  a_busy_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> strobe_o)
    else $error("sequencer busy without issuing a write");

  // a write that is not the last is followed by another
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> status.active)
    else $error("run ended without a last write");

  // unknown op codes start nothing
  a_bad_op_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i > lcd4_pkg::OP_CURSOR_CHAR) |=> !busy)
    else $error("unknown op started a run");

endmodule

// File: tb/lcd_4bit_nibble_sequencer_tb.sv
// Self-checking testbench for lcd_4bit_nibble_sequencer: queue-fed request driver,
// strobe monitor and an LCD port-write predictor. Depends on lcd4_pkg and the RTL.
module lcd_4bit_nibble_sequencer_tb;

  typedef struct {
    logic [2:0] op;
    logic [7:0] value;
    logic [1:0] row;
    logic [5:0] column;
  } lcd_req_t;

  typedef struct {
    logic [3:0] nibble;
    logic       rs;
    logic       en;
    logic [8:0] wait_units;
    logic       last;
  } port_write_t;

  localparam int unsigned NumRandReqs = 350;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] op_i = '0;
  logic [7:0] value_i = '0;
  logic [1:0] row_i = '0;
  logic [5:0] column_i = '0;
  logic       strobe_o;
  logic [3:0] data_nibble_o;
  logic       reg_select_o;
  logic       enable_o;
  logic [8:0] wait_units_o;
  logic       last_o;

  lcd_req_t    pending_req_q[$];
  port_write_t expected_writes_q[$];

  bit          took_req;
  int unsigned reqs_sent;
  int unsigned total_reqs;
  int unsigned idle_pct;
  int unsigned errors;
  int unsigned writes_checked;
  int unsigned cycles;
  int unsigned op_count[8];

  lcd_4bit_nibble_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .value_i       (value_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .strobe_o      (strobe_o),
    .data_nibble_o (data_nibble_o),
    .reg_select_o  (reg_select_o),
    .enable_o      (enable_o),
    .wait_units_o  (wait_units_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic void add_write(ref port_write_t run[$], input logic [3:0] nib,
                                    input logic rs, input logic en, input logic [8:0] wt);
    port_write_t w;
    w.nibble     = nib;
    w.rs         = rs;
    w.en         = en;
    w.wait_units = wt;
    w.last       = 1'b0;
    run.push_back(w);
  endfunction

  // high nibble first, each nibble with E high then E low
  function automatic void add_byte(ref port_write_t run[$], input logic [7:0] b,
                                   input logic rs, input logic [8:0] wt);
    add_write(run, b[7:4], rs, 1'b1, wt);
    add_write(run, b[7:4], rs, 1'b0, 9'd0);
    add_write(run, b[3:0], rs, 1'b1, wt);
    add_write(run, b[3:0], rs, 1'b0, 9'd0);
  endfunction

  function automatic logic [7:0] ddram_addr(logic [1:0] row, logic [5:0] column);
    logic [7:0] a;
    // plain 8-bit adder, wraps for out-of-range rows and columns
    a = 8'h80 + (8'(row) - 8'd1) * 8'h40 + (8'(column) - 8'd1);
    return a;
  endfunction

  function automatic void predict_port_writes(lcd_req_t r);
    port_write_t run[$];
    logic [3:0]  wake_nib[9];
    logic        wake_en[9];
    logic [8:0]  wake_wt[9];
    logic [7:0]  init_cmd[4];
    wake_nib = '{4'h0, 4'h3, 4'h3, 4'h3, 4'h3, 4'h3, 4'h3, 4'h2, 4'h2};
    wake_en  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    wake_wt  = '{9'd500, 9'd125, 9'd0, 9'd3, 9'd0, 9'd125, 9'd0, 9'd125, 9'd0};
    init_cmd = '{8'h28, 8'h0C, 8'h01, 8'h06};
    case (r.op)
      lcd4_pkg::OP_INIT: begin
        for (int i = 0; i < 9; i++) add_write(run, wake_nib[i], 1'b0, wake_en[i], wake_wt[i]);
        for (int i = 0; i < 4; i++) add_byte(run, init_cmd[i], 1'b0, lcd4_pkg::CmdWait);
      end
      lcd4_pkg::OP_CMD:    add_byte(run, r.value, 1'b0, lcd4_pkg::CmdWait);
      lcd4_pkg::OP_CHAR:   add_byte(run, r.value, 1'b1, lcd4_pkg::ChrWait);
      lcd4_pkg::OP_CURSOR: add_byte(run, ddram_addr(r.row, r.column), 1'b0, lcd4_pkg::CmdWait);
      lcd4_pkg::OP_CURSOR_CHAR: begin
        add_byte(run, ddram_addr(r.row, r.column), 1'b0, lcd4_pkg::CmdWait);
        add_byte(run, r.value, 1'b1, lcd4_pkg::ChrWait);
      end
      default: ;  // unused op codes produce no writes
    endcase
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_writes_q.push_back(run[i]);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    lcd_req_t r;
    if (rst_ni && !(start && !took_req)) begin
      // pick the sender idle rate from how far the run has got
      if (reqs_sent < 25 || reqs_sent >= total_reqs - total_reqs / 8) idle_pct = 0;
      else if (reqs_sent < total_reqs / 3) idle_pct = 53;
      else if (reqs_sent < (2 * total_reqs) / 3) idle_pct = 23;
      else idle_pct = 0;
      if (pending_req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        r = pending_req_q.pop_front();
        reqs_sent++;
        start    <= 1'b1;
        op_i     <= r.op;
        value_i  <= r.value;
        row_i    <= r.row;
        column_i <= r.column;
      end else begin
        // scramble the operands while idle
        start    <= 1'b0;
        op_i     <= 3'($urandom);
        value_i  <= 8'($urandom);
        row_i    <= 2'($urandom);
        column_i <= 6'($urandom);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    lcd_req_t    r;
    port_write_t w;
    took_req = rst_ni && start && !busy;
    if (rst_ni && strobe_o) begin
      if (expected_writes_q.size() == 0) begin
        $display("%0t: unexpected write nibble=%h rs=%b e=%b wait=%0d last=%b", $time,
                 data_nibble_o, reg_select_o, enable_o, wait_units_o, last_o);
        errors++;
      end else begin
        w = expected_writes_q.pop_front();
        writes_checked++;
        if (data_nibble_o !== w.nibble) begin
          $display("%0t: nibble expected %h actual %h", $time, w.nibble, data_nibble_o);
          errors++;
        end
        if (reg_select_o !== w.rs) begin
          $display("%0t: rs expected %b actual %b", $time, w.rs, reg_select_o);
          errors++;
        end
        if (enable_o !== w.en) begin
          $display("%0t: enable expected %b actual %b", $time, w.en, enable_o);
          errors++;
        end
        if (wait_units_o !== w.wait_units) begin
          $display("%0t: wait expected %0d actual %0d", $time, w.wait_units, wait_units_o);
          errors++;
        end
        if (last_o !== w.last) begin
          $display("%0t: last expected %b actual %b", $time, w.last, last_o);
          errors++;
        end
      end
    end
    // predict after the check: the first write of a run comes later
    if (took_req) begin
      r.op     = op_i;
      r.value  = value_i;
      r.row    = row_i;
      r.column = column_i;
      op_count[op_i]++;
      predict_port_writes(r);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d writes still expected", $time, expected_writes_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_req(logic [2:0] op, logic [7:0] value, logic [1:0] row,
                                    logic [5:0] column);
    lcd_req_t r;
    r.op     = op;
    r.value  = value;
    r.row    = row;
    r.column = column;
    pending_req_q.push_back(r);
  endfunction

  initial begin
    int unsigned n;
    int unsigned pick;
    logic [2:0]  op;
    logic [1:0]  row;
    logic [5:0]  column;

    // directed: every op, byte extremes, cursor corners and wrapped addresses
    queue_req(lcd4_pkg::OP_INIT,        8'h00, 2'd1, 6'd1);
    queue_req(lcd4_pkg::OP_CMD,         8'h00, 2'd0, 6'd0);
    queue_req(lcd4_pkg::OP_CMD,         8'hFF, 2'd3, 6'd63);
    queue_req(lcd4_pkg::OP_CMD,         8'hA5, 2'd1, 6'd1);
    queue_req(lcd4_pkg::OP_CHAR,        8'h00, 2'd2, 6'd40);
    queue_req(lcd4_pkg::OP_CHAR,        8'hFF, 2'd1, 6'd1);
    queue_req(lcd4_pkg::OP_CHAR,        8'h5A, 2'd0, 6'd63);
    queue_req(lcd4_pkg::OP_CURSOR,      8'h00, 2'd1, 6'd1);
    queue_req(lcd4_pkg::OP_CURSOR,      8'hFF, 2'd2, 6'd40);
    queue_req(lcd4_pkg::OP_CURSOR,      8'h00, 2'd1, 6'd40);
    queue_req(lcd4_pkg::OP_CURSOR,      8'h00, 2'd2, 6'd1);
    queue_req(lcd4_pkg::OP_CURSOR,      8'h00, 2'd0, 6'd0);
    queue_req(lcd4_pkg::OP_CURSOR,      8'h00, 2'd3, 6'd63);
    queue_req(lcd4_pkg::OP_CURSOR,      8'h00, 2'd2, 6'd63);
    queue_req(lcd4_pkg::OP_CURSOR_CHAR, 8'h41, 2'd1, 6'd1);
    queue_req(lcd4_pkg::OP_CURSOR_CHAR, 8'hFF, 2'd2, 6'd40);
    queue_req(lcd4_pkg::OP_CURSOR_CHAR, 8'h00, 2'd0, 6'd0);
    queue_req(lcd4_pkg::OP_CURSOR_CHAR, 8'h7E, 2'd3, 6'd63);
    queue_req(3'd5,                     8'h12, 2'd1, 6'd1);
    queue_req(3'd6,                     8'h34, 2'd2, 6'd2);
    queue_req(3'd7,                     8'h56, 2'd3, 6'd3);
    queue_req(lcd4_pkg::OP_CHAR,        8'h30, 2'd1, 6'd1);
    queue_req(lcd4_pkg::OP_INIT,        8'hFF, 2'd3, 6'd63);

    // random: mostly byte and cursor requests with legal positions
    n = 0;
    while (n < NumRandReqs) begin
      pick = $urandom_range(99);
      if (pick < 5) op = lcd4_pkg::OP_INIT;
      else if (pick < 10) op = 3'($urandom_range(7, 5));
      else op = 3'($urandom_range(4, 1));
      if ($urandom_range(99) < 85) begin
        row    = 2'($urandom_range(2, 1));
        column = 6'($urandom_range(40, 1));
      end else begin
        row    = 2'($urandom);
        column = 6'($urandom);
      end
      queue_req(op, 8'($urandom), row, column);
      if (op <= lcd4_pkg::OP_CURSOR_CHAR) n++;
    end
    total_reqs = pending_req_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_req_q.size() > 0 || start) @(posedge clk_i);
    while (expected_writes_q.size() > 0) @(posedge clk_i);
    // let any stray write show up
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d requests: init %0d, cmd %0d, char %0d, cursor %0d, cursor+char %0d,",
             total_reqs, op_count[lcd4_pkg::OP_INIT], op_count[lcd4_pkg::OP_CMD],
             op_count[lcd4_pkg::OP_CHAR], op_count[lcd4_pkg::OP_CURSOR],
             op_count[lcd4_pkg::OP_CURSOR_CHAR]);
    $display("unused ops %0d; %0d port writes checked, %0d mismatches.",
             op_count[5] + op_count[6] + op_count[7], writes_checked, errors);
    if (errors == 0 && expected_writes_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lcd4_pkg.sv
hdl/lcd4_ctrl.sv
hdl/lcd_4bit_nibble_sequencer.sv
tb/lcd_4bit_nibble_sequencer_tb.sv
